// ===== rtl/stereo_phase_correlation_meter_assert.svh =====
// Assertion macros for the stereo phase correlation meter.
// Used by the top level; needs no other file.
`ifndef STEREO_PHASE_CORRELATION_METER_ASSERT_SVH
`define STEREO_PHASE_CORRELATION_METER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPCM_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("spcm assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SPCM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("spcm assertion failed");

`endif

// ===== rtl/spcm_pkg.sv =====
// Shared constants and types of the stereo phase correlation meter.
// No dependencies; every other file but the assertion header refers to it by scoped names.
package spcm_pkg;

  localparam int SAMPLE_W         = 24;     // sample field width on the port
  localparam int COEFF_W          = 16;     // configuration data width
  localparam int OUT_W            = 16;     // correlation and balance width
  localparam int WIDTH_W          = 15;     // stereo width field
  localparam int DEF_SAMPLE_BITS  = 24;
  localparam int DEF_COEFF_BITS   = 16;
  localparam int DEF_GUARD_BITS   = 16;
  localparam int COEFF_RESET      = 65531;
  localparam int Q_BITS           = 14;     // fraction bits of the results
  localparam int ONE_Q14          = 16384;
  localparam int NORM_BITS        = 48;     // divisor limit of the correlation quotient
  localparam int QUEUE_DEPTH      = 2;

  // Front to back: one queued item.
  typedef struct packed {
    logic valid;
    logic last;
    logic cross_neg;
  } item_ctl_t;

  // Back status seen at the top level.
  typedef struct packed {
    logic busy;
    logic result_load;
  } back_stat_t;

  // Smoothed sums, updated in this order.
  typedef enum logic [2:0] {
    SUM_LL = 3'd0,
    SUM_RR = 3'd1,
    SUM_LR = 3'd2,
    SUM_AL = 3'd3,
    SUM_AR = 3'd4
  } sum_e;

endpackage

// ===== rtl/spcm_sample_if.sv =====
// Input channel of the meter: one stereo pair per request.
// Depends on spcm_pkg.
interface spcm_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [spcm_pkg::SAMPLE_W-1:0] left_sample;
  logic signed [spcm_pkg::SAMPLE_W-1:0] right_sample;
  logic                                 last_in_block;

  modport source (output valid, left_sample, right_sample, last_in_block, input ready);
  modport sink   (input valid, left_sample, right_sample, last_in_block, output ready);
endinterface

// ===== rtl/spcm_meter_if.sv =====
// Output channel of the meter: one meter result per request.
// Depends on spcm_pkg.
interface spcm_meter_if;
  logic                                valid;
  logic                                ready;
  logic signed [spcm_pkg::OUT_W-1:0]   correlation;
  logic signed [spcm_pkg::OUT_W-1:0]   balance;
  logic        [spcm_pkg::WIDTH_W-1:0] stereo_width;

  modport source (output valid, correlation, balance, stereo_width, input ready);
  modport sink   (input valid, correlation, balance, stereo_width, output ready);
endinterface

// ===== rtl/stereo_phase_correlation_meter.sv =====
// Stereo phase correlation meter: each stereo pair (signed, low SAMPLE_BITS
// bits used) updates five exponentially smoothed sums (L*L, R*R, L*R, |L|,
// |R|) with the Q0.16 factor written on cfg_we_i/cfg_data_i (reset 65531);
// a pair flagged last_in_block adds one meter request carrying correlation,
// balance and stereo width in Q1.14. The back end takes one pair at a time
// and updates each sum in turn with a shift-and-add smoothing step that
// runs one coefficient bit a cycle. A block end then adds the bit-serial
// LL*RR product and its square root (EN_W = 2*SAMPLE_BITS-1+GUARD_BITS,
// 63 by default), divisor normalization and two restoring divisions. A
// two-entry queue in front lets new pairs arrive while the back end works,
// and the output register holds a finished request while the next pair is
// taken.
// Depends on spcm_pkg, the two channel interfaces, spcm_front and spcm_back.
module stereo_phase_correlation_meter #(
  parameter int SAMPLE_BITS = spcm_pkg::DEF_SAMPLE_BITS,
  parameter int COEFF_BITS  = spcm_pkg::DEF_COEFF_BITS,
  parameter int GUARD_BITS  = spcm_pkg::DEF_GUARD_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [spcm_pkg::COEFF_W-1:0] cfg_data_i,
  spcm_sample_if.sink                  sample_i,
  spcm_meter_if.source                 meter_o
);

  `include "stereo_phase_correlation_meter_assert.svh"

  spcm_pkg::item_ctl_t    item;
  spcm_pkg::back_stat_t   stat;
  logic [SAMPLE_BITS-1:0] left_mag, right_mag;
  logic                   take;

  // Accept pairs and queue their magnitudes and signs.
  spcm_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (sample_i),
    .item_o     (item),
    .left_mag_o (left_mag),
    .right_mag_o(right_mag),
    .take_i     (take)
  );

  // Smooth the sums and produce meter requests.
  spcm_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEFF_BITS (COEFF_BITS),
    .GUARD_BITS (GUARD_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item),
    .left_mag_i (left_mag),
    .right_mag_i(right_mag),
    .take_o     (take),
    .stat_o     (stat),
    .meter_o    (meter_o)
  );

  // A loaded result shows up as a valid request in the next cycle.
  `SPCM_ASSERT_NEXT(a_load_shows, clk_i, rst_ni, stat.result_load, meter_o.valid)
  // The back end takes a queued pair only when it is idle.
  `SPCM_ASSERT_NOW(a_take_idle, clk_i, rst_ni, take, !stat.busy && item.valid)
  // Input backpressure only when the queue holds pairs.
  `SPCM_ASSERT_NOW(a_full_has_items, clk_i, rst_ni, !sample_i.ready, item.valid)

endmodule

// ===== rtl/spcm_front.sv =====
// Front end: accepts stereo pairs, takes their magnitudes and signs, and
// holds them in a short queue for the back end. Depends on spcm_pkg.
module spcm_front #(
  parameter int SAMPLE_BITS = spcm_pkg::DEF_SAMPLE_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  spcm_sample_if.sink                sample_i,
  output spcm_pkg::item_ctl_t        item_o,
  output logic [SAMPLE_BITS-1:0]     left_mag_o,
  output logic [SAMPLE_BITS-1:0]     right_mag_o,
  input  logic                       take_i
);

  localparam int PTR_W = $clog2(spcm_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(spcm_pkg::QUEUE_DEPTH + 1);

  logic [SAMPLE_BITS-1:0] lmag_q [spcm_pkg::QUEUE_DEPTH];
  logic [SAMPLE_BITS-1:0] rmag_q [spcm_pkg::QUEUE_DEPTH];
  logic                   last_q [spcm_pkg::QUEUE_DEPTH];
  logic                   xneg_q [spcm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;

  logic [SAMPLE_BITS-1:0] lraw, rraw, lmag, rmag;
  logic                   lneg, rneg, push, pop;

  // Two's complement magnitude of the low SAMPLE_BITS bits.
  assign lraw = sample_i.left_sample[SAMPLE_BITS-1:0];
  assign rraw = sample_i.right_sample[SAMPLE_BITS-1:0];
  assign lneg = lraw[SAMPLE_BITS-1];
  assign rneg = rraw[SAMPLE_BITS-1];
  assign lmag = lneg ? (~lraw + SAMPLE_BITS'(1)) : lraw;
  assign rmag = rneg ? (~rraw + SAMPLE_BITS'(1)) : rraw;

  assign sample_i.ready = (cnt_q != CNT_W'(spcm_pkg::QUEUE_DEPTH));
  assign push = sample_i.valid && sample_i.ready;
  assign pop  = take_i && (cnt_q != '0);

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PTR_W'(spcm_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PTR_W'(spcm_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      lmag_q[wptr_q] <= lmag;
      rmag_q[wptr_q] <= rmag;
      last_q[wptr_q] <= sample_i.last_in_block;
      xneg_q[wptr_q] <= lneg ^ rneg;
    end
  end

  assign item_o.valid     = (cnt_q != '0);
  assign item_o.last      = last_q[rptr_q];
  assign item_o.cross_neg = xneg_q[rptr_q];
  assign left_mag_o       = lmag_q[rptr_q];
  assign right_mag_o      = rmag_q[rptr_q];

endmodule

// ===== rtl/spcm_back.sv =====
// Back end: smooths the five sums, and on a block end works out the
// correlation, balance and width into the output register. Depends on spcm_pkg.
module spcm_back #(
  parameter int SAMPLE_BITS = spcm_pkg::DEF_SAMPLE_BITS,
  parameter int COEFF_BITS  = spcm_pkg::DEF_COEFF_BITS,
  parameter int GUARD_BITS  = spcm_pkg::DEF_GUARD_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [spcm_pkg::COEFF_W-1:0] cfg_data_i,
  input  spcm_pkg::item_ctl_t         item_i,
  input  logic [SAMPLE_BITS-1:0]      left_mag_i,
  input  logic [SAMPLE_BITS-1:0]      right_mag_i,
  output logic                        take_o,
  output spcm_pkg::back_stat_t        stat_o,
  spcm_meter_if.source                meter_o
);

  localparam int EN_W  = 2 * SAMPLE_BITS - 1 + GUARD_BITS; // energy sums
  localparam int XC_W  = EN_W + 1;                         // signed cross sum
  localparam int AM_W  = SAMPLE_BITS + GUARD_BITS;         // magnitude sums
  localparam int DF_W  = EN_W + 2;                         // term minus sum
  localparam int AC_W  = DF_W + COEFF_BITS + 1;            // scaled difference
  localparam int PR_W  = 2 * EN_W;                         // LL*RR
  localparam int RT_W  = EN_W;                             // its square root
  localparam int DV_W  = EN_W;                             // divider operands
  localparam int CNT_W = $clog2(RT_W + 1);
  localparam int QM_W  = spcm_pkg::Q_BITS + 1;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_TERM = 10'b0000000010,
    ST_MAC  = 10'b0000000100,
    ST_WB   = 10'b0000001000,
    ST_MUL  = 10'b0000010000,
    ST_SQRT = 10'b0000100000,
    ST_NORM = 10'b0001000000,
    ST_DSET = 10'b0010000000,
    ST_DIV  = 10'b0100000000,
    ST_LOAD = 10'b1000000000
  } state_e;

  state_e                   state_q, state_d;
  spcm_pkg::sum_e           sum_q, sum_d;
  logic [COEFF_BITS-1:0]    coeff_q;
  logic [SAMPLE_BITS-1:0]   lmag_q, lmag_d, rmag_q, rmag_d;
  logic                     xneg_q, xneg_d, last_q, last_d;
  logic [EN_W-1:0]          ll_q, ll_d, rr_q, rr_d;
  logic signed [XC_W-1:0]   lr_q, lr_d;
  logic [AM_W-1:0]          al_q, al_d, ar_q, ar_d;
  logic signed [AC_W-1:0]   acc_q, acc_d, shf_q, shf_d;
  logic [COEFF_BITS:0]      dcsh_q, dcsh_d;
  logic [PR_W-1:0]          mcand_q, mcand_d, prod_q, prod_d;
  logic [EN_W-1:0]          mplr_q, mplr_d;
  logic [RT_W:0]            rem_q, rem_d;
  logic [RT_W-1:0]          root_q, root_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [DV_W-1:0]          num_q, num_d, den_q, den_d, drem_q, drem_d;
  logic [QM_W-1:0]          quo_q, quo_d, cmag_q, cmag_d;
  logic                     phase_q, phase_d, bneg_q, bneg_d;
  logic                     ovld_q, ovld_d;
  logic signed [spcm_pkg::OUT_W-1:0]  corr_q, corr_d, bal_q, bal_d;
  logic [spcm_pkg::WIDTH_W-1:0]       wid_q, wid_d;

  // Datapath helpers.
  logic [SAMPLE_BITS-1:0]   op_a, op_b;
  logic [2*SAMPLE_BITS-1:0] term_prod;
  logic [EN_W-1:0]          term_mag;
  logic signed [DF_W-1:0]   term_s, sum_s;
  logic signed [AC_W-1:0]   inc_w;
  logic [RT_W+2:0]          sq_rem, sq_trial;
  logic [DV_W:0]            dv_rem;
  logic [AM_W:0]            tot_w, bdiff_w;
  logic                     out_free, fin, load;
  logic [QM_W-1:0]          fin_quo;

  assign out_free = !ovld_q || meter_o.ready;
  assign take_o   = (state_q == ST_IDLE) && item_i.valid;
  assign load     = (state_q == ST_LOAD) && out_free;

  assign term_prod = op_a * op_b;
  assign inc_w     = acc_q >>> COEFF_BITS;
  assign sq_rem    = {rem_q, prod_q[PR_W-1 -: 2]};
  assign sq_trial  = (RT_W + 3)'({root_q, 2'b01});
  assign dv_rem    = {drem_q, 1'b0};
  assign tot_w     = (AM_W + 1)'(al_q) + (AM_W + 1)'(ar_q);
  assign bdiff_w   = (al_q > ar_q) ? (AM_W + 1)'(al_q - ar_q) : (AM_W + 1)'(ar_q - al_q);

  // Select the term and current sum for the sum under update.
  always_comb begin
    op_a     = lmag_q;
    op_b     = lmag_q;
    term_mag = '0;
    sum_s    = '0;
    case (sum_q)
      spcm_pkg::SUM_LL: begin
        term_mag = EN_W'(term_prod) << GUARD_BITS;
        sum_s    = signed'(DF_W'(ll_q));
      end
      spcm_pkg::SUM_RR: begin
        op_a     = rmag_q;
        op_b     = rmag_q;
        term_mag = EN_W'(term_prod) << GUARD_BITS;
        sum_s    = signed'(DF_W'(rr_q));
      end
      spcm_pkg::SUM_LR: begin
        op_b     = rmag_q;
        term_mag = EN_W'(term_prod) << GUARD_BITS;
        sum_s    = DF_W'(lr_q);
      end
      spcm_pkg::SUM_AL: begin
        term_mag = EN_W'(lmag_q) << GUARD_BITS;
        sum_s    = signed'(DF_W'(al_q));
      end
      spcm_pkg::SUM_AR: begin
        term_mag = EN_W'(rmag_q) << GUARD_BITS;
        sum_s    = signed'(DF_W'(ar_q));
      end
      default: begin
        term_mag = '0;
      end
    endcase
    term_s = signed'(DF_W'(term_mag));
    if ((sum_q == spcm_pkg::SUM_LR) && xneg_q) begin
      term_s = -term_s;
    end
  end

  // Quotient finished this cycle (special cases in ST_DSET, last step of ST_DIV).
  always_comb begin
    fin     = 1'b0;
    fin_quo = '0;
    if (state_q == ST_DSET) begin
      if (den_q == '0) begin
        fin = 1'b1;
      end else if (num_q >= den_q) begin
        fin     = 1'b1;
        fin_quo = QM_W'(spcm_pkg::ONE_Q14);
      end
    end else if ((state_q == ST_DIV) && (cnt_q == CNT_W'(spcm_pkg::Q_BITS - 1))) begin
      fin     = 1'b1;
      fin_quo = {quo_q[QM_W-2:0], (dv_rem >= (DV_W + 1)'(den_q))};
    end
  end

  always_comb begin
    state_d = state_q;
    sum_d   = sum_q;
    lmag_d  = lmag_q;
    rmag_d  = rmag_q;
    xneg_d  = xneg_q;
    last_d  = last_q;
    ll_d    = ll_q;
    rr_d    = rr_q;
    lr_d    = lr_q;
    al_d    = al_q;
    ar_d    = ar_q;
    acc_d   = acc_q;
    shf_d   = shf_q;
    dcsh_d  = dcsh_q;
    mcand_d = mcand_q;
    mplr_d  = mplr_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    num_d   = num_q;
    den_d   = den_q;
    drem_d  = drem_q;
    quo_d   = quo_q;
    cmag_d  = cmag_q;
    phase_d = phase_q;
    bneg_d  = bneg_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_i.valid) begin
          lmag_d  = left_mag_i;
          rmag_d  = right_mag_i;
          xneg_d  = item_i.cross_neg;
          last_d  = item_i.last;
          sum_d   = spcm_pkg::SUM_LL;
          state_d = ST_TERM;
        end
      end
      ST_TERM: begin
        // S' = S + floor((X - S) * (1 - c)), run shift-and-add over (1 - c).
        shf_d   = AC_W'(term_s - sum_s);
        acc_d   = '0;
        dcsh_d  = {1'b1, {COEFF_BITS{1'b0}}} - {1'b0, coeff_q};
        state_d = ST_MAC;
      end
      ST_MAC: begin
        if (dcsh_q == '0) begin
          state_d = ST_WB;
        end else begin
          if (dcsh_q[0]) begin
            acc_d = acc_q + shf_q;
          end
          shf_d  = shf_q <<< 1;
          dcsh_d = dcsh_q >> 1;
        end
      end
      ST_WB: begin
        state_d = ST_TERM;
        case (sum_q)
          spcm_pkg::SUM_LL: begin
            ll_d  = ll_q + inc_w[EN_W-1:0];
            sum_d = spcm_pkg::SUM_RR;
          end
          spcm_pkg::SUM_RR: begin
            rr_d  = rr_q + inc_w[EN_W-1:0];
            sum_d = spcm_pkg::SUM_LR;
          end
          spcm_pkg::SUM_LR: begin
            lr_d  = lr_q + inc_w[XC_W-1:0];
            sum_d = spcm_pkg::SUM_AL;
          end
          spcm_pkg::SUM_AL: begin
            al_d  = al_q + inc_w[AM_W-1:0];
            sum_d = spcm_pkg::SUM_AR;
          end
          default: begin
            ar_d    = ar_q + inc_w[AM_W-1:0];
            mcand_d = PR_W'(ll_q);
            mplr_d  = rr_q;
            prod_d  = '0;
            state_d = last_q ? ST_MUL : ST_IDLE;
          end
        endcase
      end
      ST_MUL: begin
        // Shift-and-add LL * RR, one multiplier bit a cycle.
        if (mplr_q == '0) begin
          rem_d   = '0;
          root_d  = '0;
          cnt_d   = '0;
          state_d = ST_SQRT;
        end else begin
          if (mplr_q[0]) begin
            prod_d = prod_q + mcand_q;
          end
          mcand_d = mcand_q << 1;
          mplr_d  = mplr_q >> 1;
        end
      end
      ST_SQRT: begin
        // Restoring square root, one result bit a cycle.
        prod_d = prod_q << 2;
        if (sq_rem >= sq_trial) begin
          rem_d  = (RT_W + 1)'(sq_rem - sq_trial);
          root_d = {root_q[RT_W-2:0], 1'b1};
        end else begin
          rem_d  = (RT_W + 1)'(sq_rem);
          root_d = {root_q[RT_W-2:0], 1'b0};
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(RT_W - 1)) begin
          num_d   = lr_q[XC_W-1] ? DV_W'(-lr_q) : DV_W'(lr_q);
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        den_d = root_q;
        if (cnt_q == '0 && (den_q >> spcm_pkg::NORM_BITS) != '0) begin
          den_d = den_q >> 1;
          num_d = num_q >> 1;
        end
        if (cnt_q != '0) begin
          // First cycle here: load the root as divisor.
          cnt_d = '0;
        end else if ((den_q >> spcm_pkg::NORM_BITS) == '0) begin
          den_d   = den_q;
          phase_d = 1'b0;
          state_d = ST_DSET;
        end
      end
      ST_DSET: begin
        drem_d = num_q;
        quo_d  = '0;
        cnt_d  = '0;
        if (!fin) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // Restoring division, one quotient bit a cycle.
        if (dv_rem >= (DV_W + 1)'(den_q)) begin
          drem_d = DV_W'(dv_rem - (DV_W + 1)'(den_q));
          quo_d  = {quo_q[QM_W-2:0], 1'b1};
        end else begin
          drem_d = DV_W'(dv_rem);
          quo_d  = {quo_q[QM_W-2:0], 1'b0};
        end
        cnt_d = cnt_q + CNT_W'(1);
      end
      ST_LOAD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // Quotient done: keep the correlation and start the balance, or finish.
    if (fin) begin
      if (!phase_q) begin
        cmag_d  = fin_quo;
        num_d   = DV_W'(bdiff_w);
        den_d   = DV_W'(tot_w);
        bneg_d  = al_q > ar_q;
        phase_d = 1'b1;
        state_d = ST_DSET;
      end else begin
        quo_d   = fin_quo;
        state_d = ST_LOAD;
      end
    end
  end

  // Output register.
  always_comb begin
    ovld_d = ovld_q;
    corr_d = corr_q;
    bal_d  = bal_q;
    wid_d  = wid_q;
    if (meter_o.ready) begin
      ovld_d = 1'b0;
    end
    if (load) begin
      ovld_d = 1'b1;
      corr_d = lr_q[XC_W-1] ? -signed'(spcm_pkg::OUT_W'(cmag_q))
                            : signed'(spcm_pkg::OUT_W'(cmag_q));
      bal_d  = bneg_q ? -signed'(spcm_pkg::OUT_W'(quo_q))
                      : signed'(spcm_pkg::OUT_W'(quo_q));
      wid_d  = spcm_pkg::WIDTH_W'(spcm_pkg::ONE_Q14) - spcm_pkg::WIDTH_W'(cmag_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      coeff_q <= COEFF_BITS'(spcm_pkg::COEFF_RESET);
      ll_q    <= '0;
      rr_q    <= '0;
      lr_q    <= '0;
      al_q    <= '0;
      ar_q    <= '0;
      ovld_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        coeff_q <= COEFF_BITS'(cfg_data_i);
      end
      ll_q    <= ll_d;
      rr_q    <= rr_d;
      lr_q    <= lr_d;
      al_q    <= al_d;
      ar_q    <= ar_d;
      ovld_q  <= ovld_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q   <= sum_d;
    lmag_q  <= lmag_d;
    rmag_q  <= rmag_d;
    xneg_q  <= xneg_d;
    last_q  <= last_d;
    acc_q   <= acc_d;
    shf_q   <= shf_d;
    dcsh_q  <= dcsh_d;
    mcand_q <= mcand_d;
    mplr_q  <= mplr_d;
    prod_q  <= prod_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    num_q   <= num_d;
    den_q   <= den_d;
    drem_q  <= drem_d;
    quo_q   <= quo_d;
    cmag_q  <= cmag_d;
    bneg_q  <= bneg_d;
    corr_q  <= corr_d;
    bal_q   <= bal_d;
    wid_q   <= wid_d;
  end

  assign meter_o.valid        = ovld_q;
  assign meter_o.correlation  = corr_q;
  assign meter_o.balance      = bal_q;
  assign meter_o.stereo_width = wid_q;

  assign stat_o.busy        = (state_q != ST_IDLE);
  assign stat_o.result_load = load;

endmodule

// ===== verif/testbench.sv =====
// Testbench for the stereo phase correlation meter: a table of directed pairs, then random
// pairs under several coefficients and handshake idling modes, checked against a predictor.
// Depends on spcm_pkg, spcm_sample_if, spcm_meter_if and the meter top level.
`timescale 1ns / 100ps

module testbench;

  localparam int CLK_HALF     = 2;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int SETTLE_WAIT  = 600;      // covers queued pairs plus one block end
  localparam int PHASE_ITEMS  = 260;
  localparam int NUM_PHASES   = 6;
  localparam int DIR_ROWS     = 14;
  localparam int DIR_SPLIT    = 6;        // rows from here run with coefficient zero
  localparam logic signed [23:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] S_MIN = 24'sh800000;
  localparam logic signed [23:0] S_NMX = -24'sh7FFFFF;

  typedef struct {
    logic signed [15:0] correlation;
    logic signed [15:0] balance;
    logic        [14:0] stereo_width;
  } reading_t;

  typedef struct {
    logic signed [23:0] left;
    logic signed [23:0] right;
    bit                 last;
    bit                 typed;     // expected reading given below, not predicted
    reading_t           reading;
  } pair_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [spcm_pkg::COEFF_W-1:0] cfg_data_i;

  spcm_sample_if sample_ch ();
  spcm_meter_if  meter_ch ();

  stereo_phase_correlation_meter i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (sample_ch.sink),
    .meter_o    (meter_ch.source)
  );

  // Predictor state: coefficient and the five smoothed sums as 64-bit two's complement.
  logic [15:0]        coeff_q;
  logic signed [63:0] sum_ll, sum_rr, sum_lr, sum_al, sum_ar;

  reading_t pending_readings[$];
  int       err_count = 0;
  int       cycle_count = 0;
  int       src_idle_pct = 0;
  int       sink_stall_pct = 0;

  pair_row_t dir_rows [0:DIR_ROWS-1] = '{
    // reset coefficient: all sums start at zero, so a zero pair reads as silence
    '{24'sd0, 24'sd0, 1'b1, 1'b1, '{16'sd0, 16'sd0, 15'd16384}},
    '{S_MAX,  S_MAX,  1'b0, 1'b0, '{16'sd0, 16'sd0, 15'd0}},
    '{S_MIN,  S_MAX,  1'b1, 1'b0, '{16'sd0, 16'sd0, 15'd0}},
    '{24'sd12345, -24'sd777, 1'b0, 1'b0, '{16'sd0, 16'sd0, 15'd0}},
    '{S_MIN,  S_MIN,  1'b1, 1'b0, '{16'sd0, 16'sd0, 15'd0}},
    '{24'sd1, -24'sd1, 1'b1, 1'b0, '{16'sd0, 16'sd0, 15'd0}},
    // coefficient zero: each sum is the newest term, so readings follow the pair alone
    '{S_MAX,  S_MAX,  1'b1, 1'b1, '{16'sd16384, 16'sd0, 15'd0}},
    '{S_MAX,  S_NMX,  1'b1, 1'b1, '{-16'sd16384, 16'sd0, 15'd0}},
    '{S_MIN,  24'sd0, 1'b1, 1'b1, '{16'sd0, -16'sd16384, 15'd16384}},
    '{24'sd0, S_MIN,  1'b1, 1'b1, '{16'sd0, 16'sd16384, 15'd16384}},
    '{24'sd0, 24'sd0, 1'b1, 1'b1, '{16'sd0, 16'sd0, 15'd16384}},
    '{S_MIN,  S_MIN,  1'b0, 1'b0, '{16'sd0, 16'sd0, 15'd0}},
    '{S_MIN,  S_MIN,  1'b1, 1'b1, '{16'sd16384, 16'sd0, 15'd0}},
    '{S_MIN,  S_MAX,  1'b1, 1'b1, '{-16'sd16384, 16'sd0, 15'd0}}
  };

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  initial begin
    rst_ni                  = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_data_i              = '0;
    sample_ch.valid         = 1'b0;
    sample_ch.left_sample   = '0;
    sample_ch.right_sample  = '0;
    sample_ch.last_in_block = 1'b0;
    meter_ch.ready          = 1'b0;
  end

  // Hard stop on a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: stall at the rate of the current phase.
  always @(posedge clk_i) begin
    meter_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Compare every accepted reading with the oldest pending one.
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && meter_ch.valid && meter_ch.ready) begin
      if (pending_readings.size() == 0) begin
        $error("unexpected reading: correlation %0d balance %0d width %0d",
               meter_ch.correlation, meter_ch.balance, meter_ch.stereo_width);
        err_count++;
      end else begin
        want = pending_readings.pop_front();
        if (meter_ch.correlation !== want.correlation) begin
          $error("correlation expected %0d got %0d", want.correlation, meter_ch.correlation);
          err_count++;
        end
        if (meter_ch.balance !== want.balance) begin
          $error("balance expected %0d got %0d", want.balance, meter_ch.balance);
          err_count++;
        end
        if (meter_ch.stereo_width !== want.stereo_width) begin
          $error("stereo_width expected %0d got %0d", want.stereo_width,
                 meter_ch.stereo_width);
          err_count++;
        end
      end
    end
  end

  // One smoothing step: bits 16..79 of s*c + x*(2^16 - c), taken as a floor.
  function automatic logic signed [63:0] smooth_step(logic signed [63:0] s,
                                                     logic signed [63:0] x);
    logic signed [127:0] acc;
    acc = 128'(s) * $signed({112'd0, coeff_q})
        + 128'(x) * $signed(128'(17'h10000 - {1'b0, coeff_q}));
    return acc[79:16];
  endfunction

  function automatic logic [63:0] isqrt128(logic [127:0] p);
    logic [63:0] root;
    logic [63:0] cand;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= p) root = cand;
    end
    return root;
  endfunction

  // Update the sums for one pair; return whether a reading follows and what it is.
  function automatic bit meter_predict(logic signed [23:0] l, logic signed [23:0] r,
                                       bit last, output reading_t rd);
    logic [63:0] lmag, rmag, cmag, s, n, d, corr, tot, diff, bmag;
    bit          cneg, bneg;
    lmag = l[23] ? 64'(-$signed({l[23], l})) : 64'(l);
    rmag = r[23] ? 64'(-$signed({r[23], r})) : 64'(r);
    sum_ll = smooth_step(sum_ll, $signed((lmag * lmag) << 16));
    sum_rr = smooth_step(sum_rr, $signed((rmag * rmag) << 16));
    sum_lr = smooth_step(sum_lr, (l[23] != r[23]) ? -$signed((lmag * rmag) << 16)
                                                  : $signed((lmag * rmag) << 16));
    sum_al = smooth_step(sum_al, $signed(lmag << 16));
    sum_ar = smooth_step(sum_ar, $signed(rmag << 16));
    rd = '{16'sd0, 16'sd0, 15'd0};
    if (!last) return 1'b0;

    s    = isqrt128({64'd0, sum_ll} * {64'd0, sum_rr});
    cneg = sum_lr[63];
    cmag = cneg ? -sum_lr : sum_lr;
    if (s == 0) begin
      corr = 0;
    end else begin
      n = cmag;
      d = s;
      while (d >= (64'd1 << spcm_pkg::NORM_BITS)) begin
        d = d >> 1;
        n = n >> 1;
      end
      corr = (n >= d) ? 64'(spcm_pkg::ONE_Q14) : ((n << 14) / d);
    end

    tot  = sum_al + sum_ar;
    bneg = sum_al > sum_ar;
    diff = bneg ? sum_al - sum_ar : sum_ar - sum_al;
    if (tot == 0) begin
      bmag = 0;
    end else begin
      bmag = (diff << 14) / tot;
      if (bmag > spcm_pkg::ONE_Q14) bmag = spcm_pkg::ONE_Q14;
    end

    rd.correlation  = cneg ? -$signed(corr[15:0]) : $signed(corr[15:0]);
    rd.balance      = bneg ? -$signed(bmag[15:0]) : $signed(bmag[15:0]);
    rd.stereo_width = 15'(spcm_pkg::ONE_Q14 - corr);
    return 1'b1;
  endfunction

  // Offer one pair, hold it until accepted, then queue what it should produce.
  task automatic send_pair(pair_row_t row);
    reading_t rd;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.left_sample   <= row.left;
    sample_ch.right_sample  <= row.right;
    sample_ch.last_in_block <= row.last;
    @(posedge clk_i);
    while (!sample_ch.ready) @(posedge clk_i);
    if (meter_predict(row.left, row.right, row.last, rd))
      pending_readings.push_back(row.typed ? row.reading : rd);
  endtask

  // Drop valid, wait for every pending reading, then let queued pairs finish.
  task automatic settle();
    sample_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_coeff(logic [15:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    coeff_q     = value;
  endtask

  function automatic logic signed [23:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 24'sd0;
      1:       return S_MAX;
      2:       return S_MIN;
      3:       return $signed(24'($urandom_range(0, 255))) - 24'sd128;
      default: return $signed(24'($urandom()));
    endcase
  endfunction

  function automatic pair_row_t random_pair();
    pair_row_t row;
    row.left  = pick_sample();
    case ($urandom_range(0, 9))
      0:       row.right = row.left;
      1:       row.right = -row.left;
      2:       row.right = 24'sd0;
      default: row.right = $signed(24'($urandom()));
    endcase
    if ($urandom_range(0, 9) == 0) row.left = 24'sd0;
    row.last    = ($urandom_range(0, 3) == 0);
    row.typed   = 1'b0;
    row.reading = '{16'sd0, 16'sd0, 15'd0};
    return row;
  endfunction

  initial begin
    logic [15:0] phase_coeff [0:NUM_PHASES-1];
    int          idle_src  [0:3];
    int          idle_sink [0:3];
    phase_coeff = '{16'd65535, 16'd0, 16'd32768, 16'd65531, 16'd1, 16'd0};
    idle_src    = '{0, 58, 0, 6};
    idle_sink   = '{0, 0, 58, 6};
    phase_coeff[5] = 16'($urandom());

    coeff_q = 16'(spcm_pkg::COEFF_RESET);
    sum_ll = '0; sum_rr = '0; sum_lr = '0; sum_al = '0; sum_ar = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: reset coefficient first, then coefficient zero.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == DIR_SPLIT) begin
        settle();
        write_coeff(16'd0);
      end
      send_pair(dir_rows[i]);
    end

    // Random phases: one coefficient each, idling mode rotating.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      write_coeff(phase_coeff[ph]);
      src_idle_pct   = idle_src[ph % 4];
      sink_stall_pct = idle_sink[ph % 4];
      for (int k = 0; k < PHASE_ITEMS; k++) send_pair(random_pair());
    end

    settle();
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
